// ===== rtl/fud_pkg.sv =====
// Shared types, character codes and helpers for the form URL decoder.
package fud_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D2    = 8'h32;
  localparam logic [7:0] CH_D3    = 8'h33;
  localparam logic [7:0] CH_D4    = 8'h34;
  localparam logic [7:0] CH_D9    = 8'h39;

  // Entity positions within "&#0XY;"
  localparam logic [2:0] ENT_AMP  = 3'd0;
  localparam logic [2:0] ENT_HASH = 3'd1;
  localparam logic [2:0] ENT_ZERO = 3'd2;
  localparam logic [2:0] ENT_HI   = 3'd3;
  localparam logic [2:0] ENT_LO   = 3'd4;
  localparam logic [2:0] ENT_SEMI = 3'd5;

  typedef enum logic [2:0] {
    ESC_IDLE = 3'b001,
    ESC_HIGH = 3'b010,
    ESC_LOW  = 3'b100
  } esc_state_e;

  typedef enum logic [1:0] {
    CMD_ONE,
    CMD_TWO,
    CMD_ENT
  } cmd_kind_e;

  // One output run: a byte, a byte pair, or an entity with two digits
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] b0;
    logic [7:0] b1;
  } cmd_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ===== rtl/fud_if.sv =====
// Handshake channels for raw input bytes and decoded output bytes.
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/fud_front.sv =====
// Front end: accepts input items, tracks escape and quote state, issues run commands.
module fud_front import fud_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  fud_in_if.sink in_i,
  input  logic  full_i,
  output logic  push_o,
  output cmd_t  cmd_o
);

  esc_state_e esc_q, esc_d;
  logic [3:0] nib_q, nib_d;
  logic       quote_q, quote_d;
  logic       gen;
  logic       accept;
  logic [7:0] dec;
  cmd_t       cmd;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign dec        = {nib_q, hex_value(in_i.in_byte)};

  always_comb begin
    esc_d   = esc_q;
    nib_d   = nib_q;
    quote_d = quote_q;
    gen     = 1'b0;
    cmd     = '{kind: CMD_ONE, b0: in_i.in_byte, b1: CH_LF};
    if (in_i.end_of_input) begin
      esc_d   = ESC_IDLE;
      nib_d   = 4'd0;
      quote_d = 1'b0;
      gen     = 1'b1;
      if (quote_q) begin
        cmd = '{kind: CMD_TWO, b0: CH_DQ, b1: CH_LF};
      end else begin
        cmd = '{kind: CMD_ONE, b0: CH_LF, b1: CH_LF};
      end
    end else begin
      case (esc_q)
        ESC_HIGH: begin
          nib_d = hex_value(in_i.in_byte);
          esc_d = ESC_LOW;
        end
        ESC_LOW: begin
          esc_d = ESC_IDLE;
          nib_d = 4'd0;
          gen   = 1'b1;
          if (dec == CH_APOS) begin
            cmd = '{kind: CMD_ENT, b0: CH_D3, b1: CH_D9};
          end else if (dec == CH_BSL) begin
            cmd = '{kind: CMD_ENT, b0: CH_D9, b1: CH_D2};
          end else if (dec == CH_DQ) begin
            cmd = '{kind: CMD_ENT, b0: CH_D3, b1: CH_D4};
          end else begin
            // decoded newline only survives inside a quote
            gen = (dec != CH_LF) || quote_q;
            cmd = '{kind: CMD_ONE, b0: dec, b1: CH_LF};
          end
        end
        default: begin
          esc_d = ESC_IDLE;
          case (in_i.in_byte)
            CH_PCT: esc_d = ESC_HIGH;
            CH_PLUS: begin
              gen = 1'b1;
              cmd = '{kind: CMD_ONE, b0: CH_SPACE, b1: CH_LF};
            end
            CH_EQ: begin
              gen     = 1'b1;
              quote_d = 1'b1;
              cmd     = '{kind: CMD_TWO, b0: CH_EQ, b1: CH_DQ};
            end
            CH_FF: gen = 1'b0;
            CH_AMP: begin
              gen     = 1'b1;
              quote_d = 1'b0;
              if (quote_q) begin
                cmd = '{kind: CMD_TWO, b0: CH_DQ, b1: CH_LF};
              end else begin
                cmd = '{kind: CMD_ONE, b0: CH_LF, b1: CH_LF};
              end
            end
            default: begin
              gen = 1'b1;
              cmd = '{kind: CMD_ONE, b0: in_i.in_byte, b1: CH_LF};
            end
          endcase
        end
      endcase
    end
  end

  assign push_o = accept && gen;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= ESC_IDLE;
      nib_q   <= 4'd0;
      quote_q <= 1'b0;
    end else if (accept) begin
      esc_q   <= esc_d;
      nib_q   <= nib_d;
      quote_q <= quote_d;
    end
  end

endmodule

// ===== rtl/fud_queue.sv =====
// Small command FIFO between front and back ends.
module fud_queue import fud_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(Depth - 1);
  localparam logic [CW-1:0] Full    = CW'(Depth);

  cmd_t          mem_q [Depth];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/fud_back.sv =====
// Back end: expands the head command into output bytes, one per cycle while out_o is ready.
module fud_back import fud_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  cmd_t      cmd_i,
  output logic      pop_o,
  fud_out_if.source out_o
);

  logic [2:0] idx_q, idx_d;
  logic [7:0] byte_sel;
  logic       last;
  logic       fire;

  always_comb begin
    byte_sel = cmd_i.b0;
    last     = 1'b1;
    case (cmd_i.kind)
      CMD_ONE: begin
        byte_sel = cmd_i.b0;
        last     = 1'b1;
      end
      CMD_TWO: begin
        byte_sel = (idx_q == 3'd0) ? cmd_i.b0 : cmd_i.b1;
        last     = (idx_q != 3'd0);
      end
      CMD_ENT: begin
        last = (idx_q == ENT_SEMI);
        case (idx_q)
          ENT_AMP:  byte_sel = CH_AMP;
          ENT_HASH: byte_sel = CH_HASH;
          ENT_ZERO: byte_sel = CH_D0;
          ENT_HI:   byte_sel = cmd_i.b0;
          ENT_LO:   byte_sel = cmd_i.b1;
          default:  byte_sel = CH_SEMI;
        endcase
      end
      default: begin
        byte_sel = cmd_i.b0;
        last     = 1'b1;
      end
    endcase
  end

  assign out_o.valid       = valid_i;
  assign out_o.out_byte    = byte_sel;
  assign out_o.last_of_run = last;
  assign fire              = valid_i && out_o.ready;
  assign pop_o             = fire && last;
  assign idx_d             = last ? 3'd0 : idx_q + 3'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 3'd0;
    end else if (fire) begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== rtl/form_url_decoder_shell_quote.sv =====
// Top level of the form URL decoder with shell-style quoting.
// An item's command is registered in the queue before its first output byte is offered.
// Throughput: one item per cycle while each item yields at most one byte and the
// output is ready; two-byte and six-byte entity runs are paced by the back end's
// one-byte-per-cycle expansion. Input stalls once two commands wait.
// Reset (rst_ni low, asynchronous): escape idle, nibble and quote cleared, queue empty.
module form_url_decoder_shell_quote import fud_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  fud_in_if.sink    in_i,
  fud_out_if.source out_o
);

  // Front to queue
  logic push;
  cmd_t push_cmd;
  logic full;

  // Queue to back
  logic head_valid;
  cmd_t head_cmd;
  logic pop;

  // Front end: classifies every accepted item; items that yield nothing
  // (escape lead-in and high digit, form feed, unquoted decoded newline) push no command.
  fud_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Decouples input acceptance from multi-byte output runs.
  fud_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  // Back end: walks the head command one output byte per cycle while the output
  // is ready, and pops it when the last byte of the run is taken.
  fud_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (head_valid),
    .cmd_i   (head_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/tb_form_url_decoder_shell_quote.sv =====
// Self-checking testbench for the form URL decoder with shell-style quoting.
module tb_form_url_decoder_shell_quote;
  timeunit 1ns;
  timeprecision 1ps;

  import fud_pkg::*;

  // Hex letter bounds for the escape digit decode
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam int unsigned RANDOM_ITEMS = 220;
  localparam int unsigned HOLD_CYCLES  = 80;

  // One expected output byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  // One input item waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
  } raw_item_t;

  // Receiver stall styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_TOGGLE
  } rx_style_e;

  // Tracks decoder state, predicts the decoded text and checks it.
  class shell_text_board;
    esc_state_e   phase;
    logic [3:0]   hi_nib;
    bit           quoted;
    text_byte_t   expected_bytes[$];
    text_byte_t   cur_run[$];
    int unsigned  errors;
    int unsigned  n_items;
    int unsigned  n_ends;
    int unsigned  n_checked;
    int unsigned  n_entities;

    function new();
      phase      = ESC_IDLE;
      hi_nib     = 4'd0;
      quoted     = 1'b0;
      errors     = 0;
      n_items    = 0;
      n_ends     = 0;
      n_checked  = 0;
      n_entities = 0;
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    // Anything outside 0-9, a-f, A-F decodes as zero
    function logic [3:0] nibble_of(logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CH_D0 && c <= CH_D9) begin
        v = c - CH_D0;
      end else if (c >= CH_LOW_A && c <= CH_LOW_F) begin
        v = c - CH_LOW_A + 8'd10;
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
        v = c - CH_UP_A + 8'd10;
      end
      return v[3:0];
    endfunction

    function void put(logic [7:0] b);
      text_byte_t t;
      t.data = b;
      t.last = 1'b0;
      cur_run.push_back(t);
    endfunction

    // "&#0XY;"
    function void put_entity(logic [7:0] d_hi, logic [7:0] d_lo);
      n_entities++;
      put(CH_AMP);
      put(CH_HASH);
      put(CH_D0);
      put(d_hi);
      put(d_lo);
      put(CH_SEMI);
    endfunction

    function void note_item(logic [7:0] b, logic eoi);
      logic [7:0] d;
      n_items++;
      cur_run.delete();
      if (eoi) begin
        n_ends++;
        phase  = ESC_IDLE;
        hi_nib = 4'd0;
        if (quoted) put(CH_DQ);
        quoted = 1'b0;
        put(CH_LF);
      end else begin
        case (phase)
          ESC_HIGH: begin
            hi_nib = nibble_of(b);
            phase  = ESC_LOW;
          end
          ESC_LOW: begin
            d      = {hi_nib, nibble_of(b)};
            phase  = ESC_IDLE;
            hi_nib = 4'd0;
            case (d)
              CH_APOS: put_entity(CH_D3, CH_D9);
              CH_BSL:  put_entity(CH_D9, CH_D2);
              CH_DQ:   put_entity(CH_D3, CH_D4);
              CH_LF:   if (quoted) put(d);
              default: put(d);
            endcase
          end
          default: begin
            phase = ESC_IDLE;
            case (b)
              CH_PCT:  phase = ESC_HIGH;
              CH_PLUS: put(CH_SPACE);
              CH_EQ: begin
                put(CH_EQ);
                put(CH_DQ);
                quoted = 1'b1;
              end
              CH_FF: ;
              CH_AMP: begin
                if (quoted) put(CH_DQ);
                quoted = 1'b0;
                put(CH_LF);
              end
              default: put(b);
            endcase
          end
        endcase
      end
      if (cur_run.size() > 0) cur_run[cur_run.size() - 1].last = 1'b1;
      foreach (cur_run[i]) expected_bytes.push_back(cur_run[i]);
    endfunction

    function void check_byte(logic [7:0] b, logic last);
      text_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: output byte with nothing expected: expected none, actual %02h last %0b",
                 $time, b, last);
        return;
      end
      want = expected_bytes.pop_front();
      n_checked++;
      if (want.data !== b) begin
        errors++;
        $display("%0t: out_byte mismatch: expected %02h, actual %02h", $time, want.data, b);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: last_of_run mismatch: expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fud_in_if  in_ch ();
  fud_out_if out_ch ();

  form_url_decoder_shell_quote DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  shell_text_board sb = new();

  raw_item_t   stim_q[$];
  int unsigned n_sent;
  bit          hold_req;   // main asks the receiver for one long hold-off

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void push_item(logic [7:0] b, logic e);
    raw_item_t t;
    t.data = b;
    t.eoi  = e;
    stim_q.push_back(t);
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] n, bit upper);
    if (n < 4'd10) return CH_D0 + 8'(n);
    return (upper ? CH_UP_A : CH_LOW_A) + 8'(n) - 8'd10;
  endfunction

  // A %XY escape; decoded value biased toward the bytes that get rewritten.
  // Now and then a digit is a random byte, which may well not be hex.
  function automatic void push_escape();
    logic [7:0] v;
    case ($urandom_range(0, 6))
      0:       v = CH_APOS;
      1:       v = CH_BSL;
      2:       v = CH_DQ;
      3:       v = CH_LF;
      4:       v = CH_FF;
      default: v = 8'($urandom_range(0, 255));
    endcase
    push_item(CH_PCT, 1'b0);
    if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0);
    else push_item(hex_digit(v[7:4], 1'($urandom_range(0, 1))), 1'b0);
    if ($urandom_range(0, 9) == 0) push_item(8'($urandom_range(0, 255)), 1'b0);
    else push_item(hex_digit(v[3:0], 1'($urandom_range(0, 1))), 1'b0);
  endfunction

  function automatic void push_text(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0:       push_item(CH_PLUS, 1'b0);
        1, 2:    push_escape();
        3:       push_item(CH_FF, 1'b0);
        4:       push_item(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
        default: push_item(CH_LOW_A + 8'($urandom_range(0, 25)), 1'b0);
      endcase
    end
  endfunction

  // name=value[&name=value...] then an end marker or a trailing ampersand
  function automatic void push_record();
    int unsigned nf;
    nf = $urandom_range(1, 3);
    for (int unsigned f = 0; f < nf; f++) begin
      if (f > 0) push_item(CH_AMP, 1'b0);
      push_text($urandom_range(1, 4));
      push_item(CH_EQ, 1'b0);
      push_text($urandom_range(0, 6));
    end
    if ($urandom_range(0, 9) < 7) push_item(8'($urandom_range(0, 255)), 1'b1);
    else push_item(CH_AMP, 1'b0);
  endfunction

  function automatic void push_noise();
    int unsigned n;
    n = $urandom_range(3, 8);
    repeat (n) push_item(8'($urandom_range(0, 255)), ($urandom_range(0, 15) == 0));
  endfunction

  // Directed opening: field extremes, every rewrite rule, the odd corners
  function automatic void push_directed();
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_item(CH_PLUS, 1'b0);
    push_item(CH_FF, 1'b0);             // raw form feed is dropped
    push_item(CH_PCT, 1'b0);            // newline outside a quote: dropped
    push_item(CH_D0, 1'b0);
    push_item(CH_LOW_A, 1'b0);
    push_item(CH_AMP, 1'b0);            // unquoted ampersand: newline only
    push_item(CH_EQ, 1'b0);             // opens the quote
    push_item(CH_PCT, 1'b0);            // double quote entity
    push_item(CH_D2, 1'b0);
    push_item(CH_D2, 1'b0);
    push_item(CH_PCT, 1'b0);            // apostrophe entity
    push_item(CH_D2, 1'b0);
    push_item(8'h37, 1'b0);
    push_item(CH_PCT, 1'b0);            // backslash entity, lowercase digit
    push_item(8'h35, 1'b0);
    push_item(8'h63, 1'b0);
    push_item(CH_PCT, 1'b0);            // quoted newline passes, uppercase digit
    push_item(CH_D0, 1'b0);
    push_item(CH_UP_A, 1'b0);
    push_item(CH_PCT, 1'b0);            // plus and non-hex taken as zero digits
    push_item(CH_PLUS, 1'b0);
    push_item(8'h7A, 1'b0);
    push_item(CH_AMP, 1'b0);            // closes the quote
    push_item(CH_EQ, 1'b0);
    push_item(CH_PCT, 1'b0);            // escape left half done at the end
    push_item(CH_D4, 1'b0);
    push_item(8'hFF, 1'b1);             // end: drop escape, close quote
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: drive at the falling edge, accept on the rising edge
  // ---------------------------------------------------------------------------
  task automatic drive_item(input logic [7:0] b, input logic e);
    @(negedge clk_i);
    in_ch.valid        <= 1'b1;
    in_ch.in_byte      <= b;
    in_ch.end_of_input <= e;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    sb.note_item(b, e);
    n_sent++;
  endtask

  // Idle cycles; payload scrambled so it can't matter
  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      in_ch.valid        <= 1'b0;
      in_ch.in_byte      <= 8'($urandom_range(0, 255));
      in_ch.end_of_input <= 1'($urandom_range(0, 1));
    end
  endtask

  // Sender stops until every predicted byte has come out
  task automatic wait_for_drain();
    idle_cycles(1);
    while (sb.pending() > 0) @(negedge clk_i);
  endtask

  // Receiver blocked while the sender keeps pushing entity runs,
  // so the command queue fills and ready drops on the input
  task automatic long_hold_run();
    hold_req = 1'b1;
    repeat (5) begin
      drive_item(CH_PCT, 1'b0);
      drive_item(CH_D2, 1'b0);
      drive_item(8'h37, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready on its own stall pattern, results checked at posedge
  // ---------------------------------------------------------------------------
  initial begin
    rx_style_e   style;
    int unsigned style_left;
    int unsigned hold_left;
    style       = RX_OPEN;
    style_left  = 0;
    hold_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (style_left == 0) begin
          style      = rx_style_e'($urandom_range(0, 3));
          style_left = $urandom_range(20, 80);
        end
        style_left--;
        case (style)
          RX_OPEN:   out_ch.ready <= 1'b1;
          RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default:   out_ch.ready <= ~out_ch.ready;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_byte(out_ch.out_byte, out_ch.last_of_run);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n_directed;
    int unsigned burst;
    bit          hold_done;
    bit          drain_done;
    raw_item_t   it;

    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.in_byte      = 8'h00;
    in_ch.end_of_input = 1'b0;
    hold_req           = 1'b0;
    n_sent             = 0;
    hold_done          = 1'b0;
    drain_done         = 1'b0;

    push_directed();
    n_directed = stim_q.size();
    // Mostly well-formed records, some raw noise
    while (stim_q.size() - n_directed < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 8) push_record();
      else push_noise();
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Bursts of random length, gaps of random length, sometimes none
    while (stim_q.size() > 0) begin
      burst = $urandom_range(1, 16);
      for (int unsigned i = 0; i < burst && stim_q.size() > 0; i++) begin
        if (!hold_done && n_sent > 90) begin
          hold_done = 1'b1;
          long_hold_run();
        end
        if (!drain_done && n_sent > 190) begin
          drain_done = 1'b1;
          wait_for_drain();
        end
        it = stim_q.pop_front();
        drive_item(it.data, it.eoi);
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
    end

    idle_cycles(1);
    while (sb.pending() > 0) @(posedge clk_i);
    // Catch any stray trailing bytes
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items (%0d end markers); checked %0d output bytes, %0d entity runs.",
             sb.n_items, sb.n_ends, sb.n_checked, sb.n_entities);
    $display("Receiver ran open, random, sparse and toggling ready with one long hold-off;");
    $display("sender paused once for a full drain.");
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
